@@ sv/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_SAME_CYCLE(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

@@ sv/bda_pkg.sv @@
package bda_pkg;

    localparam int MASK_W   = 6;
    localparam int IDX_W    = 3;
    localparam int TICK_W   = 16;
    localparam int HOLD_W   = 4;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0]  REPEAT_DELAY_RST = 16'd200;
    localparam logic [TICK_W-1:0]  REPEAT_REARM_RST = 16'd150;
    localparam logic [HOLD_W-1:0]  RELEASE_HOLD_RST = 4'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'd255;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_POLL = 1'b1
    } bda_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_DELAY = 2'd0,
        CFG_REPEAT_REARM = 2'd1,
        CFG_RELEASE_HOLD = 2'd2
    } bda_cfg_idx_t;

    typedef struct packed {
        bda_req_t           req_type;
        logic [MASK_W-1:0]  pressed_mask;
        logic [IDX_W-1:0]   button_index;
    } bda_in_t;

    typedef struct packed {
        logic               press_event;
        logic [COUNT_W-1:0] pending_events;
    } bda_out_t;

    typedef struct packed {
        logic [TICK_W-1:0] repeat_delay;
        logic [TICK_W-1:0] repeat_rearm;
        logic [HOLD_W-1:0] release_hold;
    } bda_cfg_t;

    typedef struct packed {
        logic              tick;
        logic              down;
        logic              poll;
        logic [TICK_W-1:0] tick_now;
    } bda_btn_ctl_t;

endpackage

@@ sv/bda_button.sv @@
module bda_button (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bda_pkg::bda_cfg_t     cfg,
    input  bda_pkg::bda_btn_ctl_t ctl,
    output logic [7:0]            event_count
);
    import bda_pkg::*;

    logic [HOLD_W-1:0]  hold_reg,  hold_next;
    logic [TICK_W-1:0]  mark_reg,  mark_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0]  age;
    logic               new_event;

    assign event_count = count_reg;
    // wrapped age since the mark
    assign age = ctl.tick_now - mark_reg;

    always_comb
    begin
        hold_next  = hold_reg;
        mark_next  = mark_reg;
        count_next = count_reg;
        new_event  = 1'b0;
        if (ctl.tick)
        begin
            if (ctl.down)
            begin
                if (hold_reg == '0)
                begin
                    new_event = 1'b1;
                    mark_next = ctl.tick_now;
                end
                else if (age > cfg.repeat_delay)
                begin
                    new_event = 1'b1;
                    mark_next = ctl.tick_now - cfg.repeat_rearm;
                end
                if (hold_reg < cfg.release_hold)
                begin
                    hold_next = hold_reg + 1'b1;
                end
            end
            else if (hold_reg != '0)
            begin
                hold_next = hold_reg - 1'b1;
            end
            if (new_event && count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (ctl.poll && count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            mark_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            hold_reg  <= hold_next;
            mark_reg  <= mark_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/button_debounce_autorepeat.sv @@
// channel   direction  payload                                     handshake
// in        input      req_type, pressed_mask, button_index       in_valid / in_ready
// out       output     press_event, pending_events                out_valid / out_ready
// cfg       input      cfg_index, cfg_data                         cfg_we
//
// one transaction per cycle while in_ready is high; every input gives one result, valid in the cycle after acceptance
// per-button state updates in the accept cycle, the result sits in a single output register
// in_ready drops only while a result waits and out_ready is low
// reset clears the tick counter, all button state and restores register defaults
module button_debounce_autorepeat #(
    parameter int BUTTONS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bda_pkg::bda_in_t      in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bda_pkg::bda_out_t     out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import bda_pkg::*;

    bda_cfg_t           cfg_reg;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               out_valid_reg;
    bda_out_t           out_data_reg, out_data_next;
    logic               accept;
    logic               is_tick, is_poll;
    logic [COUNT_W-1:0] counts [BUTTONS];
    bda_btn_ctl_t       ctl [BUTTONS];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_tick   = accept && (in_data.req_type == REQ_TICK);
    assign is_poll   = accept && (in_data.req_type == REQ_POLL);
    assign tick_next = tick_reg + 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_btn
        logic down;
        logic hit;
        if (b < MASK_W)
        begin : g_pin
            assign down = in_data.pressed_mask[b];
        end
        else
        begin : g_nopin
            // no input pin for this button
            assign down = 1'b0;
        end
        if (b < (1 << IDX_W))
        begin : g_addr
            assign hit = (in_data.button_index == IDX_W'(b));
        end
        else
        begin : g_noaddr
            assign hit = 1'b0;
        end
        assign ctl[b] = '{tick: is_tick, down: down, poll: is_poll && hit,
                          tick_now: tick_next};

        bda_button u_button (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg         (cfg_reg),
            .ctl         (ctl[b]),
            .event_count (counts[b])
        );
    end

    always_comb
    begin
        logic [COUNT_W-1:0] sel;
        sel = '0;
        for (int b = 0; b < BUTTONS; b++)
        begin
            if (ctl[b].poll)
            begin
                sel = counts[b];
            end
        end
        out_data_next = '0;
        if (in_data.req_type == REQ_POLL && sel != '0)
        begin
            out_data_next.press_event    = 1'b1;
            out_data_next.pending_events = sel - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{repeat_delay: REPEAT_DELAY_RST, repeat_rearm: REPEAT_REARM_RST,
                         release_hold: RELEASE_HOLD_RST};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPEAT_DELAY: cfg_reg.repeat_delay <= cfg_data;
                CFG_REPEAT_REARM: cfg_reg.repeat_rearm <= cfg_data;
                CFG_RELEASE_HOLD: cfg_reg.release_hold <= cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_tick)
            begin
                tick_reg <= tick_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ sv/bda_checker.sv @@
`include "assert_macros.svh"

module bda_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input bda_pkg::bda_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input bda_pkg::bda_out_t out_data
);
    import bda_pkg::*;

    logic out_wait;
    logic tick_take;
    logic out_zero;

    assign out_wait  = out_valid && !out_ready;
    assign tick_take = in_valid && in_ready && in_data.req_type == REQ_TICK;
    assign out_zero  = out_data.press_event == 1'b0 && out_data.pending_events == '0;

    // a waiting result holds steady
    `ASSERT_NEXT_CYCLE(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data))
    // the input side stalls only behind a blocked result
    `ASSERT_SAME_CYCLE(a_ready_free, clk, rst_n, !out_valid || out_ready, in_ready)
    // a tick transaction gives an all-zero result next cycle
    `ASSERT_NEXT_CYCLE(a_tick_zero, clk, rst_n, tick_take, out_valid && out_zero)
    // no consumed event means nothing was queued
    `ASSERT_SAME_CYCLE(a_empty_poll, clk, rst_n, out_valid && !out_data.press_event, out_zero)

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (.*);

@@ tb/sv/tb_button_debounce_autorepeat.sv @@
module tb_button_debounce_autorepeat;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    localparam int BUTTONS         = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;

    typedef struct {
        bda_in_t item;
        bit      drain;
    } offer_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    bda_in_t      in_data = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    bda_out_t     out_data;
    logic         cfg_we = 1'b0;
    bda_cfg_idx_t cfg_index = CFG_REPEAT_DELAY;
    logic [15:0]  cfg_data = '0;

    // register copies and per-button state of the debounce predictor
    logic [TICK_W-1:0]  delay_cfg = REPEAT_DELAY_RST;
    logic [TICK_W-1:0]  rearm_cfg = REPEAT_REARM_RST;
    logic [HOLD_W-1:0]  hold_cap = RELEASE_HOLD_RST;
    logic [TICK_W-1:0]  ticks = '0;
    logic [HOLD_W-1:0]  hold_lvl [BUTTONS] = '{default: '0};
    logic [TICK_W-1:0]  mark [BUTTONS] = '{default: '0};
    logic [COUNT_W-1:0] queued_events [BUTTONS] = '{default: '0};

    offer_t   pending_items [$];
    bda_out_t awaited_reports [$];
    int       in_flight = 0;
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;

    button_debounce_autorepeat #(
        .BUTTONS(BUTTONS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void bump_events(int b);
        if (queued_events[b] != COUNT_MAX)
            queued_events[b] = queued_events[b] + 8'd1;
    endfunction

    function automatic bda_out_t predict_report(bda_in_t item);
        bda_out_t          rep;
        logic [TICK_W-1:0] age;
        int                b;
        rep = '0;
        if (item.req_type == REQ_TICK)
        begin
            ticks = ticks + 16'd1;
            for (b = 0; b < BUTTONS; b++)
            begin
                if (item.pressed_mask[b])
                begin
                    if (hold_lvl[b] == '0)
                    begin
                        bump_events(b);
                        mark[b] = ticks;
                    end
                    else
                    begin
                        age = ticks - mark[b];
                        if (age > delay_cfg)
                        begin
                            bump_events(b);
                            mark[b] = ticks - rearm_cfg;
                        end
                    end
                    // a level left above a lowered ceiling stays put
                    if (hold_lvl[b] < hold_cap)
                        hold_lvl[b] = hold_lvl[b] + 4'd1;
                end
                else if (hold_lvl[b] != '0)
                begin
                    hold_lvl[b] = hold_lvl[b] - 4'd1;
                end
            end
        end
        else if (item.button_index < BUTTONS)
        begin
            b = item.button_index;
            if (queued_events[b] != '0)
            begin
                queued_events[b] = queued_events[b] - 8'd1;
                rep.press_event = 1'b1;
            end
            rep.pending_events = queued_events[b];
        end
        return rep;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic add_tick(logic [MASK_W-1:0] mask, bit drain = 1'b0);
        offer_t o;
        o.item.req_type = REQ_TICK;
        o.item.pressed_mask = mask;
        o.item.button_index = IDX_W'($urandom_range(7));
        o.drain = drain;
        pending_items.push_back(o);
    endtask

    task automatic add_poll(logic [IDX_W-1:0] idx, bit drain = 1'b0);
        offer_t o;
        o.item.req_type = REQ_POLL;
        o.item.pressed_mask = MASK_W'($urandom_range(63));
        o.item.button_index = idx;
        o.drain = drain;
        pending_items.push_back(o);
    endtask

    // held masks kept for a stretch of ticks with polls mixed in, plus some noise
    task automatic add_hold_runs(int count, int drain_every = 0);
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] mask;
        int                run;
        int                added;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(1) == 0)
                    add_tick(MASK_W'($urandom_range(63)));
                else
                    add_poll(IDX_W'($urandom_range(7)));
                added++;
            end
            else
            begin
                held = MASK_W'($urandom_range(63));
                run = $urandom_range(1, 60);
                for (int i = 0; i < run && added < count; i++)
                begin
                    mask = held;
                    if ($urandom_range(9) == 0)
                        mask[$urandom_range(MASK_W - 1)] ^= 1'b1;
                    add_tick(mask, drain_every > 0 && added % drain_every == 0);
                    added++;
                    if ($urandom_range(3) == 0)
                    begin
                        if ($urandom_range(15) == 0)
                            add_poll(IDX_W'($urandom_range(7)));
                        else
                            add_poll(IDX_W'($urandom_range(BUTTONS - 1)));
                        added++;
                    end
                end
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || awaited_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(bda_cfg_idx_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] delay, logic [15:0] rearm, logic [3:0] cap);
        write_reg(CFG_REPEAT_DELAY, delay);
        write_reg(CFG_REPEAT_REARM, rearm);
        write_reg(CFG_RELEASE_HOLD, 16'(cap));
        @(negedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        bit     free;
        bit     go;
        offer_t next_offer;
        if (rst_n)
        begin
            free = !in_valid || in_ready;
            if (free)
            begin
                go = pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
                // a drain item waits until every earlier transaction has come back
                if (go && pending_items[0].drain && (in_flight != 0 || in_valid))
                    go = 1'b0;
                if (go)
                begin
                    next_offer = pending_items.pop_front();
                    in_data <= next_offer.item;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with its own count for the long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= $urandom_range(99) >= stall_pct;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        bda_out_t want;
        bit       took_in;
        bit       took_out;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REPEAT_DELAY: delay_cfg = cfg_data;
                    CFG_REPEAT_REARM: rearm_cfg = cfg_data;
                    CFG_RELEASE_HOLD: hold_cap = cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            took_out = out_valid && out_ready;
            took_in = in_valid && in_ready;
            if (took_out)
            begin
                if (awaited_reports.size() == 0)
                begin
                    flag_mismatch("result with nothing awaited, press_event", out_data.press_event, 0);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (out_data.press_event !== want.press_event)
                        flag_mismatch("press_event", out_data.press_event, want.press_event);
                    if (out_data.pending_events !== want.pending_events)
                        flag_mismatch("pending_events", out_data.pending_events,
                                      want.pending_events);
                end
            end
            if (took_in)
                awaited_reports.push_back(predict_report(in_data));
            in_flight <= in_flight + int'(took_in) - int'(took_out);
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, fresh presses, releases, empty and missing polls
        add_tick(6'h3F);
        add_tick(6'h3F);
        add_tick(6'h00);
        for (int i = 0; i < 8; i++)
            add_poll(IDX_W'(i));
        add_poll(3'd0);
        add_poll(3'd0);
        add_tick(6'h15);
        add_tick(6'h00);
        add_tick(6'h2A);
        add_poll(3'd1);
        add_poll(3'd2);
        add_poll(3'd5);
        add_poll(3'd7);
        add_poll(3'd6);
        add_hold_runs(50);
        wait_idle();

        // short repeats, deep hold ceiling, bursty sender
        set_regs(16'd3, 16'd1, 4'd15);
        send_idle_pct = 78;
        add_hold_runs(50);
        wait_idle();

        // ceiling lowered under existing levels, immediate repeats, stalling receiver
        set_regs(16'd0, 16'hFFFF, 4'd2);
        send_idle_pct = 0;
        stall_pct = 78;
        add_hold_runs(50);
        wait_idle();

        // zero ceiling: every pressed tick queues, driving counts into saturation
        set_regs(16'hFFFF, 16'd0, 4'd0);
        send_idle_pct = 21;
        stall_pct = 21;
        for (int i = 0; i < 270; i++)
        begin
            if ($urandom_range(15) == 0)
                add_tick(6'h3F ^ (MASK_W'(1) << $urandom_range(MASK_W - 1)));
            else
                add_tick(6'h3F);
        end
        for (int i = 0; i < 20; i++)
            add_poll(IDX_W'($urandom_range(7)));
        hold_requests++;
        wait_idle();

        // mixed settings with pauses until everything has come back
        set_regs(16'd10, 16'd5, 4'd1);
        add_hold_runs(60, 20);
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
